// ===== rtl/kfl_pkg.sv =====
`default_nettype none

package kfl_pkg;

   // default table depth
   localparam int MAX_KEYS_DEF = 256;

   // fixed field widths
   localparam int TIME_W    = 32;
   localparam int VAL_W     = 32;
   localparam int KEY_IDX_W = 8;
   localparam int FRAC_W    = 16;
   localparam int KCNT_W    = 9;
   localparam int NUM_COMP  = 4;

   // request kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/kfl_ifs.sv =====
`default_nettype none

// request channel: load or sample beat
interface kfl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic        [kfl_pkg::KEY_IDX_W-1:0]  key_index;
   logic signed [kfl_pkg::TIME_W-1:0]     key_time;
   logic signed [kfl_pkg::VAL_W-1:0]      key_x;
   logic signed [kfl_pkg::VAL_W-1:0]      key_y;
   logic signed [kfl_pkg::VAL_W-1:0]      key_z;
   logic signed [kfl_pkg::VAL_W-1:0]      key_w;
   logic signed [kfl_pkg::TIME_W-1:0]     query_time;

   modport source (output valid, req_type, key_index, key_time, key_x, key_y, key_z, key_w,
                   query_time, input ready);
   modport sink   (input valid, req_type, key_index, key_time, key_x, key_y, key_z, key_w,
                   query_time, output ready);
endinterface

// response channel: one beat per sample
interface kfl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [kfl_pkg::KEY_IDX_W-1:0]  lower_key;
   logic        [kfl_pkg::KEY_IDX_W-1:0]  upper_key;
   logic        [kfl_pkg::FRAC_W-1:0]     fraction;
   logic signed [kfl_pkg::VAL_W-1:0]      out_x;
   logic signed [kfl_pkg::VAL_W-1:0]      out_y;
   logic signed [kfl_pkg::VAL_W-1:0]      out_z;
   logic signed [kfl_pkg::VAL_W-1:0]      out_w;
   logic                                  clamped;

   modport source (output valid, lower_key, upper_key, fraction, out_x, out_y, out_z, out_w,
                   clamped, input ready);
   modport sink   (input valid, lower_key, upper_key, fraction, out_x, out_y, out_z, out_w,
                   clamped, output ready);
endinterface

`default_nettype wire

// ===== rtl/keyframe_search_and_lerp.sv =====
// Load beats: accepted in idle, written to the tables at the accepting edge, no response.
// Sample beats: two bound reads, at most ceil(log2(n)) time-table reads (n = clamped
// key count), prep, radix-2 divider, shared lerp multiplier, done. Below key 0 the
// second bound read and the search are skipped, at/past the last key only the search.
// One sample at a time: next beat accepted from the cycle in which the response goes valid.
// Reset (synchronous, active high): idle, response dropped, key_count 1, tables undefined.
`default_nettype none

module keyframe_search_and_lerp #(
   parameter int MAX_KEYS = kfl_pkg::MAX_KEYS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   kfl_req_if.sink                     req,
   kfl_rsp_if.source                   rsp,
   input  wire                         csr_wr_en,
   input  wire [kfl_pkg::KCNT_W-1:0]   csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_KEYS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int TW     = kfl_pkg::TIME_W;
   localparam int VW     = kfl_pkg::VAL_W;
   localparam int FW     = kfl_pkg::FRAC_W;
   localparam int NC     = kfl_pkg::NUM_COMP;
   localparam int DW     = TW + 1;
   localparam int PW     = VW + 1 + FW + 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_CHK0 = 8'b0000_0010,
      S_CHKN = 8'b0000_0100,
      S_SRCH = 8'b0000_1000,
      S_PREP = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_MUL  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   typedef logic signed [VW-1:0] comp_type [NC];

   // tables
   logic signed [TW-1:0]      time_mem [MAX_KEYS];
   logic [NC*VW-1:0]          val_mem  [MAX_KEYS];

   // control
   state_type                 state_ff, state_in;
   logic [kfl_pkg::KCNT_W-1:0] key_count_ff;
   logic [3:0]                cnt_ff, cnt_in;
   logic                      clamp_ff, clamp_in;

   // search
   logic signed [TW-1:0]      q_ff, q_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [TW-1:0]      t_lo_ff, t_lo_in, t_hi_ff, t_hi_in;
   logic signed [TW-1:0]      t_rd_ff;
   logic [NC*VW-1:0]          val_rd_ff;
   logic [IDX_W-1:0]          t_addr, v_addr;

   // divider
   logic [DW-1:0]             r_ff, r_in, d_ff, d_in;
   logic [FW-1:0]             quot_ff, quot_in;

   // lerp
   comp_type                  v0_ff, v1_ff, res_ff;
   logic signed [DW-1:0]      diff_ff;
   logic signed [PW-1:0]      prod_ff;
   logic signed [VW-1:0]      b1_ff, b2_ff;

   // response register
   logic                      rsp_valid_ff;
   logic [kfl_pkg::KEY_IDX_W-1:0] rsp_lo_ff, rsp_hi_ff;
   logic [FW-1:0]             rsp_frac_ff;
   comp_type                  rsp_val_ff;
   logic                      rsp_clamp_ff;

   logic                      req_fire, rsp_load;
   logic [CNT_W-1:0]          n_sel;
   logic [CNT_W:0]            mid_sum;
   logic                      ge_q;
   logic [DW:0]               r2;
   logic                      r_ge;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   // clamp key_count into 1..MAX_KEYS
   always_comb begin
      if (key_count_ff == '0) begin
         n_sel = CNT_W'(1);
      end else if (int'(key_count_ff) > MAX_KEYS) begin
         n_sel = CNT_W'(MAX_KEYS);
      end else begin
         n_sel = CNT_W'(key_count_ff);
      end
   end

   // divider step
   assign r2   = {r_ff, 1'b0};
   assign r_ge = (r2 >= {1'b0, d_ff});
   assign ge_q = (q_ff >= t_rd_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      clamp_in = clamp_ff;
      q_in     = q_ff;
      n_in     = n_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      t_lo_in  = t_lo_ff;
      t_hi_in  = t_hi_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      quot_in  = quot_ff;
      t_addr   = '0;
      mid_sum  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req.req_type == kfl_pkg::REQ_SAMPLE) begin
               q_in     = req.query_time;
               n_in     = n_sel;
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            // t_rd_ff holds time of key 0
            t_lo_in = t_rd_ff;
            if (!ge_q) begin
               lo_in    = '0;
               hi_in    = '0;
               clamp_in = 1'b1;
               state_in = S_PREP;
            end else begin
               t_addr   = IDX_W'(n_ff - CNT_W'(1));
               state_in = S_CHKN;
            end
         end
         S_CHKN: begin
            // t_rd_ff holds time of the last key
            t_hi_in = t_rd_ff;
            if (ge_q) begin
               lo_in    = n_ff - CNT_W'(1);
               hi_in    = n_ff - CNT_W'(1);
               clamp_in = 1'b1;
               state_in = S_PREP;
            end else begin
               lo_in    = '0;
               hi_in    = n_ff;
               clamp_in = 1'b0;
               mid_sum  = {1'b0, n_ff};
               mid_in   = mid_sum[CNT_W:1];
               t_addr   = IDX_W'(mid_in);
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            // t_rd_ff holds time of key mid_ff
            if (ge_q) begin
               lo_in   = mid_ff;
               t_lo_in = t_rd_ff;
            end else begin
               hi_in   = mid_ff;
               t_hi_in = t_rd_ff;
            end
            mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
            mid_in  = mid_sum[CNT_W:1];
            t_addr  = IDX_W'(mid_in);
            if (hi_in - lo_in <= CNT_W'(1)) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // value read of lo is issued here
            if (clamp_ff) begin
               r_in = '0;
               d_in = DW'(1);
            end else begin
               r_in = {q_ff[TW-1], q_ff} - {t_lo_ff[TW-1], t_lo_ff};
               d_in = {t_hi_ff[TW-1], t_hi_ff} - {t_lo_ff[TW-1], t_lo_ff};
            end
            quot_in  = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            r_in    = r_ge ? DW'(r2 - {1'b0, d_ff}) : r2[DW-1:0];
            quot_in = {quot_ff[FW-2:0], r_ge};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign v_addr = (state_ff == S_PREP) ? IDX_W'(lo_ff) : IDX_W'(hi_ff);

   // tables: write on load beats, one registered read each per cycle
   always_ff @(posedge clock) begin
      if (req_fire && req.req_type == kfl_pkg::REQ_LOAD && int'(req.key_index) < MAX_KEYS) begin
         time_mem[IDX_W'(req.key_index)] <= req.key_time;
         val_mem[IDX_W'(req.key_index)]  <= {req.key_w, req.key_z, req.key_y, req.key_x};
      end
      t_rd_ff   <= time_mem[t_addr];
      val_rd_ff <= val_mem[v_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_count_ff <= kfl_pkg::KCNT_W'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            key_count_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      clamp_ff <= clamp_in;
      q_ff     <= q_in;
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      t_lo_ff  <= t_lo_in;
      t_hi_ff  <= t_hi_in;
      r_ff     <= r_in;
      d_ff     <= d_in;
      quot_ff  <= quot_in;

      // capture the two value rows during the divide
      if (state_ff == S_DIV && cnt_ff == 4'd0) begin
         for (int i = 0; i < NC; i++) begin
            v0_ff[i] <= val_rd_ff[i*VW +: VW];
         end
      end
      if (state_ff == S_DIV && cnt_ff == 4'd1) begin
         for (int i = 0; i < NC; i++) begin
            v1_ff[i] <= val_rd_ff[i*VW +: VW];
         end
      end

      // lerp pipe: diff, multiply, add; components rotate through slot 0
      if (state_ff == S_MUL) begin
         diff_ff <= {v1_ff[0][VW-1], v1_ff[0]} - {v0_ff[0][VW-1], v0_ff[0]};
         prod_ff <= diff_ff * $signed({1'b0, quot_ff});
         b1_ff   <= v0_ff[0];
         b2_ff   <= b1_ff;
         for (int i = 0; i < NC - 1; i++) begin
            v0_ff[i] <= v0_ff[i+1];
            v1_ff[i] <= v1_ff[i+1];
         end
         v0_ff[NC-1] <= v0_ff[0];
         v1_ff[NC-1] <= v1_ff[0];
         if (cnt_ff >= 4'd2) begin
            for (int i = 0; i < NC - 1; i++) begin
               res_ff[i] <= res_ff[i+1];
            end
            res_ff[NC-1] <= b2_ff + prod_ff[FW +: VW];
         end
      end

      // response payload
      if (rsp_load) begin
         rsp_lo_ff    <= kfl_pkg::KEY_IDX_W'(lo_ff);
         rsp_hi_ff    <= kfl_pkg::KEY_IDX_W'(hi_ff);
         rsp_frac_ff  <= quot_ff;
         rsp_val_ff   <= res_ff;
         rsp_clamp_ff <= clamp_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.lower_key = rsp_lo_ff;
   assign rsp.upper_key = rsp_hi_ff;
   assign rsp.fraction  = rsp_frac_ff;
   assign rsp.out_x     = rsp_val_ff[0];
   assign rsp.out_y     = rsp_val_ff[1];
   assign rsp.out_z     = rsp_val_ff[2];
   assign rsp.out_w     = rsp_val_ff[3];
   assign rsp.clamped   = rsp_clamp_ff;

endmodule

`default_nettype wire

// ===== verif/tb_keyframe_search_and_lerp.sv =====
module tb_keyframe_search_and_lerp;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   TIME_W       = kfl_pkg::TIME_W;
   localparam int   VAL_W        = kfl_pkg::VAL_W;
   localparam int   KEY_IDX_W    = kfl_pkg::KEY_IDX_W;
   localparam int   FRAC_W       = kfl_pkg::FRAC_W;
   localparam int   KCNT_W       = kfl_pkg::KCNT_W;
   localparam int   NUM_COMP     = kfl_pkg::NUM_COMP;
   localparam int   MAX_KEYS_DEF = kfl_pkg::MAX_KEYS_DEF;
   localparam logic REQ_LOAD     = kfl_pkg::REQ_LOAD;
   localparam logic REQ_SAMPLE   = kfl_pkg::REQ_SAMPLE;

   localparam logic [TIME_W-1:0] MIN_Q = 32'h8000_0000;
   localparam logic [TIME_W-1:0] MAX_Q = 32'h7FFF_FFFF;
   localparam int SETTLE_CYCLES = 40;   // worst sample latency plus margin
   localparam int PHASES        = 12;
   localparam int RANDOM_BEATS  = 13;   // per phase

   // one request beat, as the block sees it
   typedef struct packed {
      logic                            req_type;
      logic [KEY_IDX_W-1:0]            key_index;
      logic signed [TIME_W-1:0]        key_time;
      logic [NUM_COMP-1:0][VAL_W-1:0]  key_val;    // [0] = x ... [3] = w
      logic signed [TIME_W-1:0]        query_time;
   } kf_beat_type;

   // one response beat
   typedef struct packed {
      logic [KEY_IDX_W-1:0]            lower_key;
      logic [KEY_IDX_W-1:0]            upper_key;
      logic [FRAC_W-1:0]               fraction;
      logic [NUM_COMP-1:0][VAL_W-1:0]  comp;
      logic                            clamped;
   } lerp_result_type;

   // Mirror of the keyframe tables plus the queue of samples still owed.
   class keyframe_tracker;
      bit signed [TIME_W-1:0] time_tab [MAX_KEYS_DEF];
      bit [VAL_W-1:0]         val_tab  [NUM_COMP][MAX_KEYS_DEF];
      bit [KCNT_W-1:0]        key_count = 1;
      lerp_result_type        due_samples [$];
      int                     errors;
      string                  comp_name [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

      function void set_key_count(bit [KCNT_W-1:0] v);
         key_count = v;
      endfunction

      // floor(a*(1-t) + b*t) with t in Q0.16, exact in 64 bits
      function bit [VAL_W-1:0] blend(bit [VAL_W-1:0] a, bit [VAL_W-1:0] b,
                                     bit [FRAC_W-1:0] t);
         longint acc;
         acc = longint'($signed(a)) * (longint'(65536) - longint'(t))
             + longint'($signed(b)) * longint'(t);
         acc = acc >>> 16;
         return acc[VAL_W-1:0];
      endfunction

      // load: update tables; sample: search, divide, blend, queue the result
      function void take_beat(kf_beat_type b);
         int              n, lo, hi, mid;
         longint          q, t0, t1;
         lerp_result_type r;
         if (b.req_type == REQ_LOAD) begin
            time_tab[b.key_index] = b.key_time;
            for (int c = 0; c < NUM_COMP; c++) val_tab[c][b.key_index] = b.key_val[c];
            return;
         end
         n = (key_count == 0) ? 1 : ((key_count > MAX_KEYS_DEF) ? MAX_KEYS_DEF : key_count);
         q = $signed(b.query_time);
         r = '0;
         if (q < time_tab[0]) begin
            lo = 0;
            hi = 0;
            r.clamped = 1'b1;
         end else if (q >= time_tab[n-1]) begin
            lo = n - 1;
            hi = n - 1;
            r.clamped = 1'b1;
         end else begin
            // invariant: time[lo] <= q < time[hi]
            lo = 0;
            hi = n;
            while (hi - lo > 1) begin
               mid = (lo + hi) / 2;
               if (q >= time_tab[mid]) lo = mid;
               else hi = mid;
            end
            t0 = time_tab[lo];
            t1 = time_tab[hi];
            r.fraction = FRAC_W'(((q - t0) << 16) / (t1 - t0));
         end
         r.lower_key = lo[KEY_IDX_W-1:0];
         r.upper_key = hi[KEY_IDX_W-1:0];
         for (int c = 0; c < NUM_COMP; c++)
            r.comp[c] = blend(val_tab[c][lo], val_tab[c][hi], r.fraction);
         due_samples = {due_samples, r};
      endfunction

      function void report_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_sample(lerp_result_type got);
         lerp_result_type want;
         if (due_samples.size() == 0) begin
            $display("%0t: response beat with no sample outstanding, got %h", $time, got);
            errors++;
            return;
         end
         want = due_samples.pop_front();
         report_field("lower_key", VAL_W'(want.lower_key), VAL_W'(got.lower_key));
         report_field("upper_key", VAL_W'(want.upper_key), VAL_W'(got.upper_key));
         report_field("fraction", VAL_W'(want.fraction), VAL_W'(got.fraction));
         for (int c = 0; c < NUM_COMP; c++) report_field(comp_name[c], want.comp[c], got.comp[c]);
         report_field("clamped", VAL_W'(want.clamped), VAL_W'(got.clamped));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [KCNT_W-1:0]   csr_wr_data;

   kfl_req_if req_ch ();
   kfl_rsp_if rsp_ch ();

   keyframe_tracker sb;
   bit              slot_loaded [MAX_KEYS_DEF];
   int              gap_pct   = 0;
   int              stall_pct = 0;

   keyframe_search_and_lerp uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // value with a bias toward the extremes
   function automatic logic [VAL_W-1:0] rand_val();
      case ($urandom_range(19))
         0: return MIN_Q;
         1: return MAX_Q;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // query time: mostly on or between keys, sometimes outside or anywhere
   function automatic logic [TIME_W-1:0] pick_query(input int n);
      int     k;
      longint t0, t1;
      k  = $urandom_range(n - 1);
      t0 = sb.time_tab[k];
      t1 = (k + 1 < n) ? sb.time_tab[k+1] : t0;
      case ($urandom_range(9))
         0: return $urandom;
         1: return MIN_Q;
         2: return MAX_Q;
         3: return TIME_W'(t0 - 1);
         4, 5: return TIME_W'(t0);
         default: begin
            if (t1 > t0) return TIME_W'(t0 + longint'({$urandom, $urandom} % $unsigned(t1 - t0)));
            return $urandom;
         end
      endcase
   endfunction

   // present one beat, with a random idle gap first, and hold it until taken
   task automatic drive_beat(input kf_beat_type b);
      @(negedge clock);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= b.req_type;
      req_ch.key_index  <= b.key_index;
      req_ch.key_time   <= b.key_time;
      req_ch.key_x      <= b.key_val[0];
      req_ch.key_y      <= b.key_val[1];
      req_ch.key_z      <= b.key_val[2];
      req_ch.key_w      <= b.key_val[3];
      req_ch.query_time <= b.query_time;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.take_beat(b);
      if (b.req_type == REQ_LOAD) slot_loaded[b.key_index] = 1'b1;
   endtask

   task automatic load_key(input logic [KEY_IDX_W-1:0] idx, input logic [TIME_W-1:0] t,
                           input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                           input logic [VAL_W-1:0] z, input logic [VAL_W-1:0] w);
      kf_beat_type b;
      b.req_type   = REQ_LOAD;
      b.key_index  = idx;
      b.key_time   = t;
      b.key_val    = {w, z, y, x};
      b.query_time = $urandom;
      drive_beat(b);
   endtask

   task automatic sample_at(input logic [TIME_W-1:0] q);
      kf_beat_type b;
      b.req_type   = REQ_SAMPLE;
      b.key_index  = KEY_IDX_W'($urandom);
      b.key_time   = $urandom;
      b.key_val    = {$urandom, $urandom, $urandom, $urandom};
      b.query_time = q;
      drive_beat(b);
   endtask

   // slots 0..n-1 with non-decreasing times: dense with ties, medium or full span
   task automatic load_ascending_table(input int n);
      longint stamp, room, cap;
      case ($urandom_range(2))
         0: cap = 64'sd8;
         1: cap = 64'd1 << 20;
         default: cap = 64'h1_0000_0000;
      endcase
      stamp = ($urandom_range(3) == 0) ? -64'sd2147483648
                                       : (longint'($signed($urandom)) >>> 1);
      for (int k = 0; k < n; k++) begin
         if (k != 0) begin
            room = (64'sd2147483647 - stamp) / (n - k);
            if (room > cap) room = cap;
            stamp += longint'({$urandom, $urandom} % ($unsigned(room) + 1));
         end
         load_key(KEY_IDX_W'(k), stamp[TIME_W-1:0], rand_val(), rand_val(), rand_val(),
                  rand_val());
      end
   endtask

   // drop valid, wait for every owed sample, then let a pending load finish
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_key_count(input logic [KCNT_W-1:0] v);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_key_count(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: random backpressure, check every accepted beat
   initial begin
      lerp_result_type got;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.lower_key = rsp_ch.lower_key;
            got.upper_key = rsp_ch.upper_key;
            got.fraction  = rsp_ch.fraction;
            got.comp      = {rsp_ch.out_w, rsp_ch.out_z, rsp_ch.out_y, rsp_ch.out_x};
            got.clamped   = rsp_ch.clamped;
            sb.match_sample(got);
         end
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // stimulus
   initial begin
      int  plan [PHASES];
      int  eff, k, roll;
      bit  fresh;
      sb = new();
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_LOAD;
      req_ch.key_index  <= '0;
      req_ch.key_time   <= '0;
      req_ch.key_x      <= '0;
      req_ch.key_y      <= '0;
      req_ch.key_z      <= '0;
      req_ch.key_w      <= '0;
      req_ch.query_time <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // single key at reset count: below, at and past it all clamp
      load_key('0, 32'h0001_0000, MAX_Q, MIN_Q, '0, '1);
      sample_at(MIN_Q);
      sample_at(32'h0001_0000);
      sample_at(MAX_Q);
      load_key(8'hFF, MAX_Q, rand_val(), rand_val(), rand_val(), rand_val());

      // count of zero behaves as one
      program_key_count('0);
      sample_at('0);
      sample_at(32'h0001_0000);

      // two keys spanning the whole time range, opposite extreme values
      program_key_count(KCNT_W'(2));
      load_key('0, MIN_Q, MIN_Q, MAX_Q, '0, '1);
      load_key(KEY_IDX_W'(1), MAX_Q, MAX_Q, MIN_Q, '1, '0);
      sample_at(MIN_Q);
      sample_at('1);
      sample_at(MAX_Q - 1);
      sample_at(MAX_Q);
      sample_at('0);

      // third key out of order: last key earlier than the middle one
      program_key_count(KCNT_W'(3));
      load_key(KEY_IDX_W'(2), '0, rand_val(), rand_val(), rand_val(), rand_val());
      sample_at(-32'sd5);
      sample_at(32'd100);
      sample_at(MAX_Q);

      // random phases: counts include both ends and out-of-range values
      plan = '{4, 256, 511, 257, 2, 7, 0, 33, 1, 3, 0, 0};
      plan[10] = $urandom_range(2, 48);
      plan[11] = $urandom_range(65, 200);
      for (int p = 0; p < PHASES; p++) begin
         program_key_count(KCNT_W'(plan[p]));
         eff = (plan[p] == 0) ? 1 : ((plan[p] > MAX_KEYS_DEF) ? MAX_KEYS_DEF : plan[p]);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 72; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 72; end
            default: begin gap_pct = 7; stall_pct = 7; end
         endcase
         // never sample a table with an unwritten slot in range
         fresh = (eff <= 64);
         for (k = 0; k < eff; k++) if (!slot_loaded[k]) fresh = 1'b1;
         if (fresh) load_ascending_table(eff);
         repeat (RANDOM_BEATS) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
               sample_at(pick_query(eff));
            end else if (roll < 92) begin
               // new values, same time: keeps the table in order
               k = $urandom_range(eff - 1);
               load_key(KEY_IDX_W'(k), sb.time_tab[k], rand_val(), rand_val(), rand_val(),
                        rand_val());
            end else begin
               load_key(KEY_IDX_W'($urandom), $urandom, rand_val(), rand_val(), rand_val(),
                        rand_val());
            end
         end
      end

      settle();
      if (sb.errors == 0 && sb.due_samples.size() == 0)
         $display("** keyframe_search_and_lerp: PASSED **");
      else
         $display("** keyframe_search_and_lerp: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #12_000_000;
      $display("** keyframe_search_and_lerp: FAILED **");
      $finish;
   end

endmodule
